// ===== hdl/lgts_pkg.sv =====
// ----------------------------------------------------------------------------
// lgts_pkg: shared types and constants for the toroidal life grid
// Command codes, register map and reset values used by the grid block.
// ----------------------------------------------------------------------------
package lgts_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int CMD_W     = 2;
    localparam int COORD_W   = 7;
    localparam int ELAPSED_W = 16;
    localparam int SIZE_W    = 8;
    localparam int IVAL_W    = 24;
    localparam int ACC_W     = 25;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int MIN_SIZE  = 3;

    localparam logic [SIZE_W-1:0] RST_WIDTH    = 8'd128;
    localparam logic [SIZE_W-1:0] RST_HEIGHT   = 8'd128;
    localparam logic [IVAL_W-1:0] RST_INTERVAL = 24'd100000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TOGGLE_CELL  = 2'd0,
        CMD_TOGGLE_PAUSE = 2'd1,
        CMD_CLEAR        = 2'd2,
        CMD_TICK         = 2'd3
    } cmd_t;

    localparam logic [ADDR_W-1:0] REG_WIDTH    = 4'h0;
    localparam logic [ADDR_W-1:0] REG_HEIGHT   = 4'h4;
    localparam logic [ADDR_W-1:0] REG_INTERVAL = 4'h8;

    typedef struct packed {
        logic changed;
        logic alive;
    } row_stat_t;

endpackage

// ===== hdl/lgts_row_calc.sv =====
// ----------------------------------------------------------------------------
// lgts_row_calc: next generation of one row
// Applies B3/S23 to the middle of a three-row window, wrapping columns at
// the active width; columns beyond the width keep their old value.
// ----------------------------------------------------------------------------
module lgts_row_calc #(
    parameter int MAX_WIDTH = lgts_pkg::DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH + 1),
    parameter int CA        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic [MAX_WIDTH-1:0] prev_row,
    input  logic [MAX_WIDTH-1:0] cur_row,
    input  logic [MAX_WIDTH-1:0] nxt_row,
    input  logic [CW-1:0]        width,
    output logic [MAX_WIDTH-1:0] new_row,
    output lgts_pkg::row_stat_t  stat
);
    import lgts_pkg::*;

    logic [CA-1:0]        last_col;
    logic                 p_last, c_last, n_last;
    logic [MAX_WIDTH-1:0] in_use;
    logic [MAX_WIDTH-1:0] calc;

    assign last_col = CA'(width - CW'(1));
    assign p_last   = prev_row[last_col];
    assign c_last   = cur_row[last_col];
    assign n_last   = nxt_row[last_col];

    for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_col
        logic       pl, cl, nl, pr, cr, nr, at_end;
        logic [3:0] cnt;

        assign at_end = (CW'(x) == width - CW'(1));
        if (x == 0) begin : g_first
            assign pl = p_last;
            assign cl = c_last;
            assign nl = n_last;
        end
        else begin : g_mid
            assign pl = prev_row[x-1];
            assign cl = cur_row[x-1];
            assign nl = nxt_row[x-1];
        end
        if (x == MAX_WIDTH - 1) begin : g_last
            assign pr = prev_row[0];
            assign cr = cur_row[0];
            assign nr = nxt_row[0];
        end
        else begin : g_inner
            // wrap to column zero at the active edge
            assign pr = at_end ? prev_row[0] : prev_row[x+1];
            assign cr = at_end ? cur_row[0]  : cur_row[x+1];
            assign nr = at_end ? nxt_row[0]  : nxt_row[x+1];
        end

        assign cnt = 4'(pl) + 4'(prev_row[x]) + 4'(pr) + 4'(cl) + 4'(cr)
                   + 4'(nl) + 4'(nxt_row[x]) + 4'(nr);
        assign calc[x]   = (cnt == 4'd3) || (cur_row[x] && cnt == 4'd2);
        assign in_use[x] = (CW'(x) < width);
    end

    assign new_row      = (calc & in_use) | (cur_row & ~in_use);
    assign stat.changed = |((calc ^ cur_row) & in_use);
    assign stat.alive   = |(calc & in_use);

endmodule

// ===== hdl/life_grid_torus_step_top.sv =====
// ----------------------------------------------------------------------------
// life_grid_torus_step_top: Game of Life on a wrapping grid
// Command-driven B3/S23 grid held in a row memory, with APB registers.
// ----------------------------------------------------------------------------
// One command is taken while busy is low; its result appears one cycle wide
// on done and must be taken then, as the receiver cannot stall. Pause, clear,
// ticks that do not step and out-of-range toggles answer from idle, a cell
// toggle reads its row and then writes it back, and a tick that steps reads
// the row memory once per row into a three-row window and writes each new
// row back in the same cycle, so the single read port sets the pace.
module life_grid_torus_step_top #(
    parameter int MAX_WIDTH  = lgts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lgts_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lgts_pkg::ADDR_W-1:0]    paddr,
    input  logic [lgts_pkg::DATA_W-1:0]    pwdata,
    output logic [lgts_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [lgts_pkg::CMD_W-1:0]     cmd,
    input  logic [lgts_pkg::COORD_W-1:0]   col,
    input  logic [lgts_pkg::COORD_W-1:0]   row,
    input  logic [lgts_pkg::ELAPSED_W-1:0] elapsed,
    output logic                           done,
    output logic                           cell_value,
    output logic                           coord_error,
    output logic                           stepped,
    output logic                           any_changed,
    output logic                           is_paused,
    output logic                           is_over
);
    import lgts_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CA  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RA  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SWW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int SWH = (HW > SIZE_W) ? HW : SIZE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TGL,
        S_LD1,
        S_LD2,
        S_ROW,
        S_END
    } state_t;

    state_t state_reg;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [IVAL_W-1:0] interval_reg;
    logic              paused_reg, over_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic [COORD_W-1:0] tcol_reg;
    logic [RA-1:0]      trow_reg;
    logic [HW-1:0]      y_reg;
    logic               chg_reg, alive_reg;

    logic [MAX_WIDTH-1:0] prev_reg, cur_reg, row0_reg;

    logic [MAX_WIDTH-1:0]  grid_mem [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] row_valid_reg;
    logic [MAX_WIDTH-1:0]  rd_q_reg;
    logic                  rd_valid_reg;

    logic [RA-1:0]        rd_addr, wr_addr;
    logic                 wr_en;
    logic [MAX_WIDTH-1:0] wr_data, rd_data, nxt_row, calc_row, tgl_row;
    row_stat_t            calc_stat;

    logic [CW-1:0]  w_eff;
    logic [HW-1:0]  h_eff, y_plus2;
    logic [SWW-1:0] w_ext;
    logic [SWH-1:0] h_ext;
    logic           accept, in_range, do_step;
    logic [ACC_W-1:0] acc_next;
    cmd_t           cmd_in;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
            interval_reg <= RST_INTERVAL;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                REG_WIDTH:    width_reg    <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:   height_reg   <= pwdata[SIZE_W-1:0];
                REG_INTERVAL: interval_reg <= pwdata[IVAL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_WIDTH:    prdata = DATA_W'(width_reg);
            REG_HEIGHT:   prdata = DATA_W'(height_reg);
            REG_INTERVAL: prdata = DATA_W'(interval_reg);
            default:      prdata = '0;
        endcase
    end

    // clamp sizes to the supported range
    always_comb
    begin
        w_ext = SWW'(width_reg);
        h_ext = SWH'(height_reg);
        if (w_ext < SWW'(MIN_SIZE))
            w_eff = CW'(MIN_SIZE);
        else if (w_ext > SWW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(w_ext);
        if (h_ext < SWH'(MIN_SIZE))
            h_eff = HW'(MIN_SIZE);
        else if (h_ext > SWH'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(h_ext);
    end

    // ---------------- command decode ----------------
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign cmd_in   = cmd_t'(cmd);
    assign in_range = (SWW'(col) < SWW'(w_eff)) && (SWH'(row) < SWH'(h_eff));
    assign acc_next = acc_reg + ACC_W'(elapsed);
    assign do_step  = !paused_reg && !over_reg && (acc_next >= ACC_W'(interval_reg));
    assign y_plus2  = y_reg + HW'(2);

    // ---------------- row memory ----------------
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;
    assign nxt_row = (y_reg == h_eff - HW'(1)) ? row0_reg : rd_data;
    assign tgl_row = rd_data ^ (MAX_WIDTH'(1) << tcol_reg);

    always_comb
    begin
        rd_addr = RA'(row);
        wr_en   = 1'b0;
        wr_addr = trow_reg;
        wr_data = tgl_row;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_in == CMD_TICK)
                    rd_addr = RA'(h_eff - HW'(1));
            end
            S_TGL:
            begin
                wr_en = 1'b1;
            end
            S_LD1:
            begin
                rd_addr = '0;
            end
            S_LD2:
            begin
                rd_addr = RA'(1);
            end
            S_ROW:
            begin
                rd_addr = (y_plus2 < h_eff) ? RA'(y_plus2) : '0;
                wr_en   = 1'b1;
                wr_addr = RA'(y_reg);
                wr_data = calc_row;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
        rd_q_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= row_valid_reg[rd_addr];
            if (accept && cmd_in == CMD_CLEAR)
                row_valid_reg <= '0;
            else if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    lgts_row_calc #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW),
        .CA        (CA)
    ) u_row_calc (
        .prev_row (prev_reg),
        .cur_row  (cur_reg),
        .nxt_row  (nxt_row),
        .width    (w_eff),
        .new_row  (calc_row),
        .stat     (calc_stat)
    );

    // window registers carry no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                tcol_reg <= col;
                trow_reg <= RA'(row);
            end
            S_LD1:
                prev_reg <= rd_data;
            S_LD2:
            begin
                cur_reg  <= rd_data;
                row0_reg <= rd_data;
            end
            S_ROW:
            begin
                prev_reg <= cur_reg;
                cur_reg  <= nxt_row;
            end
            default: ;
        endcase
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            paused_reg  <= 1'b1;
            over_reg    <= 1'b0;
            acc_reg     <= '0;
            y_reg       <= '0;
            chg_reg     <= 1'b0;
            alive_reg   <= 1'b0;
            done        <= 1'b0;
            cell_value  <= 1'b0;
            coord_error <= 1'b0;
            stepped     <= 1'b0;
            any_changed <= 1'b0;
            is_paused   <= 1'b1;
            is_over     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cell_value  <= 1'b0;
                        coord_error <= 1'b0;
                        stepped     <= 1'b0;
                        any_changed <= 1'b0;
                        is_paused   <= paused_reg;
                        is_over     <= over_reg;
                        case (cmd_in)
                            CMD_TOGGLE_CELL:
                            begin
                                if (in_range)
                                    state_reg <= S_TGL;
                                else
                                begin
                                    coord_error <= 1'b1;
                                    done        <= 1'b1;
                                end
                            end
                            CMD_TOGGLE_PAUSE:
                            begin
                                if (!over_reg)
                                begin
                                    paused_reg <= !paused_reg;
                                    is_paused  <= !paused_reg;
                                end
                                done <= 1'b1;
                            end
                            CMD_CLEAR:
                            begin
                                paused_reg <= 1'b1;
                                over_reg   <= 1'b0;
                                acc_reg    <= '0;
                                is_paused  <= 1'b1;
                                is_over    <= 1'b0;
                                done       <= 1'b1;
                            end
                            CMD_TICK:
                            begin
                                if (do_step)
                                begin
                                    acc_reg   <= '0;
                                    state_reg <= S_LD1;
                                end
                                else
                                begin
                                    if (!paused_reg && !over_reg)
                                        acc_reg <= acc_next;
                                    done <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_TGL:
                begin
                    cell_value <= tgl_row[tcol_reg];
                    over_reg   <= 1'b0;
                    is_over    <= 1'b0;
                    done       <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                S_LD1:
                    state_reg <= S_LD2;
                S_LD2:
                begin
                    y_reg     <= '0;
                    chg_reg   <= 1'b0;
                    alive_reg <= 1'b0;
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    chg_reg   <= chg_reg | calc_stat.changed;
                    alive_reg <= alive_reg | calc_stat.alive;
                    y_reg     <= y_reg + HW'(1);
                    if (y_reg == h_eff - HW'(1))
                        state_reg <= S_END;
                end
                S_END:
                begin
                    stepped     <= 1'b1;
                    any_changed <= chg_reg;
                    // halt on a still or empty grid
                    if (!chg_reg || !alive_reg)
                    begin
                        over_reg   <= 1'b1;
                        paused_reg <= 1'b1;
                        is_over    <= 1'b1;
                        is_paused  <= 1'b1;
                    end
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the toroidal life grid
// Drives cell toggles, pause toggles, clears and time ticks through the
// command port, reprograms grid size and step interval over APB between
// phases, and checks every result word against a B3/S23 torus predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import lgts_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXH = DEF_MAX_HEIGHT;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic cell_value;
        logic coord_error;
        logic stepped;
        logic any_changed;
        logic is_paused;
        logic is_over;
    } life_res_t;

    class life_scoreboard;
        bit        cells [MAXH][MAXW];
        bit        paused;
        bit        over;
        bit [24:0] acc;
        bit [7:0]  width_reg;
        bit [7:0]  height_reg;
        bit [23:0] interval_reg;
        life_res_t pending[$];
        int        errors;

        function new();
            foreach (cells[y, x]) cells[y][x] = 0;
            paused = 1;
            over = 0;
            acc = 0;
            width_reg = RST_WIDTH;
            height_reg = RST_HEIGHT;
            interval_reg = RST_INTERVAL;
            errors = 0;
        endfunction

        function int eff_size(int v, int mx);
            if (v < MIN_SIZE) return MIN_SIZE;
            if (v > mx) return mx;
            return v;
        endfunction

        function bit evolve(int w, int h);
            bit nxt [MAXH][MAXW];
            bit changed;
            bit all_dead;
            int n;
            changed = 0;
            all_dead = 1;
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    n = 0;
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++)
                            if ((dx != 0 || dy != 0) &&
                                cells[(y + h + dy) % h][(x + w + dx) % w])
                                n++;
                    nxt[y][x] = (n == 3) || (cells[y][x] && n == 2);
                    if (nxt[y][x] != cells[y][x]) changed = 1;
                end
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                begin
                    cells[y][x] = nxt[y][x];
                    if (nxt[y][x]) all_dead = 0;
                end
            if (!changed || all_dead)
            begin
                over = 1;
                paused = 1;
            end
            return changed;
        endfunction

        function void note_command(cmd_t c, int cl, int rw, int el);
            life_res_t r;
            int w;
            int h;
            r = '0;
            w = eff_size(width_reg, MAXW);
            h = eff_size(height_reg, MAXH);
            case (c)
                CMD_TOGGLE_CELL:
                    if (cl >= w || rw >= h) r.coord_error = 1;
                    else
                    begin
                        cells[rw][cl] = !cells[rw][cl];
                        r.cell_value = cells[rw][cl];
                        over = 0;
                    end
                CMD_TOGGLE_PAUSE:
                    if (!over) paused = !paused;
                CMD_CLEAR:
                begin
                    foreach (cells[y, x]) cells[y][x] = 0;
                    paused = 1;
                    over = 0;
                    acc = 0;
                end
                default:
                    if (!paused && !over)
                    begin
                        acc = acc + el;
                        if (acc >= interval_reg)
                        begin
                            acc = 0;
                            r.stepped = 1;
                            r.any_changed = evolve(w, h);
                        end
                    end
            endcase
            r.is_paused = paused;
            r.is_over = over;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(life_res_t got);
            life_res_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %b", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
                $display("%0t: result mismatch expected %b (cv,ce,st,ch,p,o) actual %b",
                         $time, exp_r, got);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic start = 0;
    logic busy;
    logic [CMD_W-1:0] cmd = '0;
    logic [COORD_W-1:0] col = '0, row = '0;
    logic [ELAPSED_W-1:0] elapsed = '0;
    logic done, cell_value, coord_error, stepped, any_changed, is_paused, is_over;

    life_scoreboard grid_sb;
    int idle_pct;
    longint cycles;

    always #1 clk = ~clk;

    life_grid_torus_step_top uut (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            grid_sb.check_result({cell_value, coord_error, stepped, any_changed,
                                  is_paused, is_over});
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [ADDR_W-1:0] a, logic [31:0] d);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (a)
            REG_WIDTH:  grid_sb.width_reg = d[7:0];
            REG_HEIGHT: grid_sb.height_reg = d[7:0];
            default:    grid_sb.interval_reg = d[23:0];
        endcase
    endtask

    // Drop start, wait for the scoreboard to empty, then let a stepping tick finish.
    task automatic drain();
        start <= 0;
        while (grid_sb.pending.size() != 0) @(posedge clk);
        repeat (MAXH + 10) @(posedge clk);
    endtask

    // Hold start until accepted; predict at the accepting edge.
    // Start stays high on return so that words can follow back to back.
    task automatic send(cmd_t c, int cl, int rw, int el);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        start <= 1;
        cmd <= c;
        col <= COORD_W'(cl);
        row <= COORD_W'(rw);
        elapsed <= ELAPSED_W'(el);
        do @(posedge clk); while (busy);
        grid_sb.note_command(c, cl, rw, el);
    endtask

    // Biased random command: mostly toggles and running ticks.
    task automatic random_cmd(int w, int h);
        int p;
        p = $urandom_range(99);
        if (p < 45)
            send(CMD_TOGGLE_CELL,
                 ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(w - 1),
                 ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(h - 1), 0);
        else if (p < 55)
            send(CMD_TOGGLE_PAUSE, $urandom_range(127), $urandom_range(127), 0);
        else if (p < 58)
            send(CMD_CLEAR, $urandom_range(127), $urandom_range(127), $urandom_range(65535));
        else
            send(CMD_TICK, $urandom_range(127), $urandom_range(127),
                 ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40));
    endtask

    initial
    begin
        int wv, hv;
        grid_sb = new();
        cycles = 0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Defaults: full grid, corner and edge toggles, blinker at the seam
        send(CMD_TOGGLE_CELL, 127, 127, 0);
        send(CMD_TOGGLE_CELL, 0, 0, 0);
        send(CMD_TOGGLE_CELL, 0, 0, 0);
        send(CMD_TICK, 0, 0, 65535);
        send(CMD_TOGGLE_CELL, 127, 0, 0);
        send(CMD_TOGGLE_CELL, 0, 0, 0);
        send(CMD_TOGGLE_CELL, 1, 0, 0);
        send(CMD_TOGGLE_PAUSE, 0, 0, 0);
        send(CMD_TICK, 0, 0, 65535);
        send(CMD_TICK, 0, 0, 65535);
        drain();
        write_reg(REG_INTERVAL, 0);
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 200);
        send(CMD_TOGGLE_CELL, 3, 0, 0);
        send(CMD_TOGGLE_CELL, 2, 127, 0);
        send(CMD_TICK, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0);
        send(CMD_TOGGLE_PAUSE, 0, 0, 0);
        send(CMD_TOGGLE_PAUSE, 0, 0, 0);
        send(CMD_CLEAR, 0, 0, 0);
        send(CMD_TOGGLE_CELL, 1, 1, 0);
        send(CMD_TOGGLE_PAUSE, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0);
        send(CMD_TOGGLE_PAUSE, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 62;
                2: idle_pct = 34;
                default: idle_pct = 0;
            endcase
            wv = (ph % 3 == 0) ? $urandom_range(255) : $urandom_range(3, 12);
            hv = (ph == 11) ? 128 : (ph % 5 == 0) ? $urandom_range(255)
                                                  : $urandom_range(3, 12);
            write_reg(REG_WIDTH, (ph == 2) ? 32'hFFFF_FF80 : wv);
            write_reg(REG_HEIGHT, (ph == 4) ? 3 : hv);
            write_reg(REG_INTERVAL, (ph == 7) ? 32'hFFFF_FFFF :
                                    (ph % 2) ? $urandom_range(1, 60) : $urandom_range(3));
            wv = grid_sb.eff_size(grid_sb.width_reg, MAXW);
            hv = grid_sb.eff_size(grid_sb.height_reg, MAXH);
            send(CMD_CLEAR, 0, 0, 0);
            for (int i = 0; i < 85; i++)
            begin
                random_cmd(wv, hv);
                // Keep the grid running most of the time
                if (grid_sb.paused && !grid_sb.over && $urandom_range(2) != 0)
                    send(CMD_TOGGLE_PAUSE, 0, 0, 0);
            end
            drain();
        end

        if (grid_sb.errors == 0 && grid_sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
